// File: design/pwm_period_duty_autorange_macros.svh
// assertion macros shared by the pwm period and duty manager
`ifndef PWM_PERIOD_DUTY_AUTORANGE_MACROS_SVH
`define PWM_PERIOD_DUTY_AUTORANGE_MACROS_SVH

// same-cycle implication
`define PWMPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwmpd same-cycle check failed");

// next-cycle implication
`define PWMPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwmpd next-cycle check failed");

`endif

// File: design/pwmpd_pkg.sv
// types and codes for the pwm period and duty manager
`timescale 1ns / 1ps
package pwmpd_pkg;

    localparam logic [3:0] ACT_PERIOD_NOW = 4'd0;
    localparam logic [3:0] ACT_PERIOD_OVF = 4'd1;
    localparam logic [3:0] ACT_CHAN_PWM   = 4'd2;
    localparam logic [3:0] ACT_DUTY       = 4'd3;
    localparam logic [3:0] ACT_INC_PERIOD = 4'd4;
    localparam logic [3:0] ACT_DEC_PERIOD = 4'd5;
    localparam logic [3:0] ACT_INC_DUTY   = 4'd6;
    localparam logic [3:0] ACT_DEC_DUTY   = 4'd7;
    localparam logic [3:0] ACT_DISABLE    = 4'd8;
    localparam logic [3:0] ACT_OVERFLOW   = 4'd9;

    localparam logic [2:0] PS_DIV1    = 3'd0;
    localparam logic [2:0] PS_DIV8    = 3'd1;
    localparam logic [2:0] PS_DIV64   = 3'd2;
    localparam logic [2:0] PS_DIV256  = 3'd3;
    localparam logic [2:0] PS_DIV1024 = 3'd4;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_NONINV = 2'd1;
    localparam logic [1:0] MODE_INV    = 2'd2;

    typedef struct packed {
        logic [3:0]  action;
        logic        channel;
        logic [21:0] period_us;
        logic [15:0] duty_fraction;
        logic        invert;
    } t_in_word;

    typedef struct packed {
        logic [15:0] top_count;
        logic [2:0]  prescale_code;
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [1:0]  mode_a;
        logic [1:0]  mode_b;
        logic        update_pending;
    } t_out_word;

    // classified command held in the queue
    typedef struct packed {
        logic [3:0]  action;
        logic        channel;
        logic [15:0] duty_fraction;
        logic        invert;
        logic        period_nz;
        logic [15:0] conv_top;
        logic [2:0]  conv_sel;
    } t_cmd;

endpackage

// File: design/pwmpd_front.sv
// front end: converts the period to top count and prescaler, builds the command
`timescale 1ns / 1ps
module pwmpd_front #(
    parameter int CLOCKS_PER_US = 16,
    parameter int MAX_PERIOD    = 65535
) (
    input  pwmpd_pkg::t_in_word i_word,
    output pwmpd_pkg::t_cmd     o_cmd
);

    localparam int CYC_W = 22 + $clog2(CLOCKS_PER_US + 1);
    localparam logic [CYC_W-1:0] CYC_MAX = CYC_W'(MAX_PERIOD);

    logic [CYC_W-1:0] cyc;
    logic [CYC_W-1:0] cyc8;
    logic [CYC_W-1:0] cyc64;
    logic [CYC_W-1:0] cyc256;
    logic [CYC_W-1:0] cyc1024;
    logic [15:0]      top;
    logic [2:0]       sel;

    assign cyc     = CYC_W'(CLOCKS_PER_US) * CYC_W'(i_word.period_us);
    assign cyc8    = cyc >> 3;
    assign cyc64   = cyc >> 6;
    assign cyc256  = cyc >> 8;
    assign cyc1024 = cyc >> 10;

    always_comb begin
        if (cyc < CYC_MAX) begin
            top = cyc[15:0];
            sel = pwmpd_pkg::PS_DIV1;
        end else if (cyc8 <= CYC_MAX) begin
            top = cyc8[15:0];
            sel = pwmpd_pkg::PS_DIV8;
        end else if (cyc64 <= CYC_MAX) begin
            top = cyc64[15:0];
            sel = pwmpd_pkg::PS_DIV64;
        end else if (cyc256 <= CYC_MAX) begin
            top = cyc256[15:0];
            sel = pwmpd_pkg::PS_DIV256;
        end else if (cyc1024 <= CYC_MAX) begin
            top = cyc1024[15:0];
            sel = pwmpd_pkg::PS_DIV1024;
        end else begin
            // beyond the largest prescaler: saturate
            top = 16'(MAX_PERIOD);
            sel = pwmpd_pkg::PS_DIV1024;
        end
    end

    always_comb begin
        o_cmd.action        = i_word.action;
        o_cmd.channel       = i_word.channel;
        o_cmd.duty_fraction = i_word.duty_fraction;
        o_cmd.invert        = i_word.invert;
        o_cmd.period_nz     = (i_word.period_us != 22'd0);
        o_cmd.conv_top      = top;
        o_cmd.conv_sel      = sel;
    end

endmodule

// File: design/pwmpd_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
module pwmpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pwmpd_pkg::t_cmd   i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output pwmpd_pkg::t_cmd   o_cmd,
    output logic [1:0]        o_count
);

    pwmpd_pkg::t_cmd r_mem [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: design/pwmpd_back.sv
// back end: holds the timer state and carries out one command per cycle while the output is not stalled
`timescale 1ns / 1ps
module pwmpd_back #(
    parameter int MAX_PERIOD    = 65535,
    parameter int MIN_PERIOD    = 3,
    parameter int COUNTER_RANGE = 65536,
    parameter int MIN_DUTY      = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  pwmpd_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output pwmpd_pkg::t_out_word o_data
);

    localparam logic [15:0] MIN_D    = 16'(MIN_DUTY);
    localparam logic [15:0] MIN_P    = 16'(MIN_PERIOD);
    localparam logic [16:0] MAX_P17  = 17'(MAX_PERIOD);
    localparam logic [16:0] FLOOR_LO = 17'(COUNTER_RANGE / 8);
    localparam logic [16:0] FLOOR_HI = 17'(COUNTER_RANGE / 4);

    logic [15:0] r_wanted_top, n_wanted_top;
    logic [15:0] r_active_top, n_active_top;
    logic [2:0]  r_sel, n_sel;
    logic        r_pending, n_pending;
    logic [15:0] r_duty_a, n_duty_a;
    logic [15:0] r_duty_b, n_duty_b;
    logic [1:0]  r_mode_a, n_mode_a;
    logic [1:0]  r_mode_b, n_mode_b;
    logic        r_out_valid, n_out_valid;

    logic [31:0] prod;
    logic [15:0] set_val;
    logic [15:0] hi_cur;
    logic [15:0] duty_sel;
    logic [16:0] inc_next;
    logic [16:0] floor_val;
    logic [1:0]  new_mode;

    // upper duty bound for a given top; zero when top is below the minimum duty
    function automatic logic [15:0] f_upper(input logic [15:0] top);
        f_upper = (top >= MIN_D) ? top - MIN_D : 16'd0;
    endfunction

    // the upper bound wins when the two bounds cross
    function automatic logic [15:0] f_clamp(input logic [15:0] d, input logic [15:0] top);
        logic [15:0] hi;
        logic [15:0] r;
        hi = f_upper(top);
        r  = (d < MIN_D) ? MIN_D : d;
        if (r > hi) begin
            r = hi;
        end
        f_clamp = r;
    endfunction

    assign o_pop   = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;

    always_comb begin
        o_data.top_count      = r_active_top;
        o_data.prescale_code  = r_sel;
        o_data.compare_a      = r_duty_a;
        o_data.compare_b      = r_duty_b;
        o_data.mode_a         = r_mode_a;
        o_data.mode_b         = r_mode_b;
        o_data.update_pending = r_pending;
    end

    assign prod      = 32'(r_active_top) * 32'(i_cmd.duty_fraction);
    assign set_val   = f_clamp(prod[31:16], r_active_top);
    assign hi_cur    = f_upper(r_active_top);
    assign duty_sel  = i_cmd.channel ? r_duty_b : r_duty_a;
    assign inc_next  = {1'b0, r_wanted_top} + 17'd1;
    assign floor_val = (r_sel <= pwmpd_pkg::PS_DIV64) ? FLOOR_LO : FLOOR_HI;
    assign new_mode  = i_cmd.invert ? pwmpd_pkg::MODE_INV : pwmpd_pkg::MODE_NONINV;

    always_comb begin
        n_wanted_top = r_wanted_top;
        n_active_top = r_active_top;
        n_sel        = r_sel;
        n_pending    = r_pending;
        n_duty_a     = r_duty_a;
        n_duty_b     = r_duty_b;
        n_mode_a     = r_mode_a;
        n_mode_b     = r_mode_b;
        if (o_pop) begin
            case (i_cmd.action)
                pwmpd_pkg::ACT_PERIOD_NOW: begin
                    n_wanted_top = i_cmd.conv_top;
                    n_active_top = i_cmd.conv_top;
                    n_sel        = i_cmd.conv_sel;
                    n_duty_a     = f_clamp(r_duty_a, i_cmd.conv_top);
                    n_duty_b     = f_clamp(r_duty_b, i_cmd.conv_top);
                    n_pending    = 1'b0;
                end
                pwmpd_pkg::ACT_PERIOD_OVF: begin
                    n_wanted_top = i_cmd.conv_top;
                    n_sel        = i_cmd.conv_sel;
                    n_pending    = 1'b1;
                end
                pwmpd_pkg::ACT_CHAN_PWM: begin
                    if (i_cmd.period_nz) begin
                        n_wanted_top = i_cmd.conv_top;
                        n_sel        = i_cmd.conv_sel;
                        n_pending    = 1'b1;
                    end
                    if (i_cmd.channel) begin
                        n_mode_b = new_mode;
                        n_duty_b = set_val;
                    end else begin
                        n_mode_a = new_mode;
                        n_duty_a = set_val;
                    end
                end
                pwmpd_pkg::ACT_DUTY: begin
                    if (i_cmd.channel) begin
                        n_duty_b = set_val;
                    end else begin
                        n_duty_a = set_val;
                    end
                end
                pwmpd_pkg::ACT_INC_PERIOD: begin
                    n_wanted_top = inc_next[15:0];
                    if (inc_next > MAX_P17) begin
                        case (r_sel)
                            pwmpd_pkg::PS_DIV1: begin
                                n_wanted_top = 16'(inc_next >> 3);
                                n_sel        = pwmpd_pkg::PS_DIV8;
                            end
                            pwmpd_pkg::PS_DIV8: begin
                                n_wanted_top = 16'(inc_next >> 3);
                                n_sel        = pwmpd_pkg::PS_DIV64;
                            end
                            pwmpd_pkg::PS_DIV64: begin
                                n_wanted_top = 16'(inc_next >> 2);
                                n_sel        = pwmpd_pkg::PS_DIV256;
                            end
                            pwmpd_pkg::PS_DIV256: begin
                                n_wanted_top = 16'(inc_next >> 2);
                                n_sel        = pwmpd_pkg::PS_DIV1024;
                            end
                            default: begin
                                n_wanted_top = 16'(MAX_PERIOD);
                            end
                        endcase
                    end
                    n_pending = 1'b1;
                end
                pwmpd_pkg::ACT_DEC_PERIOD: begin
                    if (r_sel == pwmpd_pkg::PS_DIV1) begin
                        n_wanted_top = (r_wanted_top > MIN_P) ? r_wanted_top - 16'd1 : MIN_P;
                    end else if ({1'b0, r_wanted_top} >= floor_val) begin
                        n_wanted_top = r_wanted_top - 16'd1;
                    end else begin
                        // drop to the next smaller prescaler at full range
                        n_wanted_top = 16'(MAX_PERIOD);
                        n_sel = (r_sel >= pwmpd_pkg::PS_DIV1024) ? pwmpd_pkg::PS_DIV256
                                                                  : r_sel - 3'd1;
                    end
                    n_pending = 1'b1;
                end
                pwmpd_pkg::ACT_INC_DUTY: begin
                    if (duty_sel < hi_cur) begin
                        if (i_cmd.channel) begin
                            n_duty_b = r_duty_b + 16'd1;
                        end else begin
                            n_duty_a = r_duty_a + 16'd1;
                        end
                    end
                end
                pwmpd_pkg::ACT_DEC_DUTY: begin
                    if (duty_sel > MIN_D) begin
                        if (i_cmd.channel) begin
                            n_duty_b = r_duty_b - 16'd1;
                        end else begin
                            n_duty_a = r_duty_a - 16'd1;
                        end
                    end
                end
                pwmpd_pkg::ACT_DISABLE: begin
                    if (i_cmd.channel) begin
                        n_mode_b = pwmpd_pkg::MODE_OFF;
                    end else begin
                        n_mode_a = pwmpd_pkg::MODE_OFF;
                    end
                end
                pwmpd_pkg::ACT_OVERFLOW: begin
                    if (r_pending) begin
                        n_active_top = r_wanted_top;
                        n_duty_a     = f_clamp(r_duty_a, r_wanted_top);
                        n_duty_b     = f_clamp(r_duty_b, r_wanted_top);
                        n_pending    = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_stall) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_top <= 16'hffff;
            r_active_top <= 16'hffff;
            r_sel        <= pwmpd_pkg::PS_DIV1;
            r_pending    <= 1'b0;
            r_duty_a     <= MIN_D;
            r_duty_b     <= MIN_D;
            r_mode_a     <= pwmpd_pkg::MODE_NONINV;
            r_mode_b     <= pwmpd_pkg::MODE_NONINV;
            r_out_valid  <= 1'b0;
        end else begin
            r_wanted_top <= n_wanted_top;
            r_active_top <= n_active_top;
            r_sel        <= n_sel;
            r_pending    <= n_pending;
            r_duty_a     <= n_duty_a;
            r_duty_b     <= n_duty_b;
            r_mode_a     <= n_mode_a;
            r_mode_b     <= n_mode_b;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

// File: design/pwm_period_duty_autorange.sv
// an accepted word is first written into the queue, then applied by the back end to its state registers
// throughput: one word per cycle while the output is not stalled; the back end applies one command per
// cycle, and its state registers double as the output register
// a two-entry queue decouples input stall from output stall
// reset (synchronous, active low): top 65535, prescaler 1, duties at minimum,
// both channels non-inverting, nothing pending, queue empty
`timescale 1ns / 1ps
`include "pwm_period_duty_autorange_macros.svh"
module pwm_period_duty_autorange #(
    parameter int CLOCKS_PER_US = 16,
    parameter int MAX_PERIOD    = 65535,
    parameter int MIN_PERIOD    = 3,
    parameter int COUNTER_RANGE = 65536,
    parameter int MIN_DUTY      = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pwmpd_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output pwmpd_pkg::t_out_word o_data
);

    pwmpd_pkg::t_cmd front_cmd;
    pwmpd_pkg::t_cmd q_cmd;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic [1:0]      q_count;
    logic            push;
    logic [15:0]     out_hi;

    assign push    = i_valid && !q_full;
    assign o_stall = q_full;

    pwmpd_front #(
        .CLOCKS_PER_US (CLOCKS_PER_US),
        .MAX_PERIOD    (MAX_PERIOD)
    ) u_front (
        .i_word (i_data),
        .o_cmd  (front_cmd)
    );

    pwmpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_count (q_count)
    );

    pwmpd_back #(
        .MAX_PERIOD    (MAX_PERIOD),
        .MIN_PERIOD    (MIN_PERIOD),
        .COUNTER_RANGE (COUNTER_RANGE),
        .MIN_DUTY      (MIN_DUTY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    // duty upper bound for the applied top, for checking only
    assign out_hi = (o_data.top_count >= 16'(MIN_DUTY)) ?
                    o_data.top_count - 16'(MIN_DUTY) : 16'd0;

    `PWMPD_ASSERT_NEXT(a_accept_lands_in_queue, i_clk, i_rst_n, i_valid && !o_stall, q_count != 2'd0)
    `PWMPD_ASSERT_IMP(a_prescale_in_range, i_clk, i_rst_n, o_valid, o_data.prescale_code <= pwmpd_pkg::PS_DIV1024)
    `PWMPD_ASSERT_IMP(a_duty_a_bounded, i_clk, i_rst_n, o_valid, o_data.compare_a <= out_hi)
    `PWMPD_ASSERT_IMP(a_duty_b_bounded, i_clk, i_rst_n, o_valid, o_data.compare_b <= out_hi)

endmodule
